FILE: src/dstt_pkg.sv
// Shared constants, codes and control structs for the deadline sorted task table.
`default_nettype none
package dstt_pkg;

   localparam int ENTRIES  = 8;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int COUNT_W  = $clog2(ENTRIES + 1);
   localparam int ACTIVE_W = 4;
   localparam int ID_W     = 16;
   localparam int GEN_W    = 2;
   localparam int DL_W     = 32;
   localparam int TALLY_W  = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [OP_W-1:0] {
      OP_RELEASE  = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_OVERDUE  = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic                load;
      logic                step;
      logic                apply_release;
      logic                apply_remove;
      logic                set_status;
      logic [STATUS_W-1:0] status_val;
      logic                load_out;
   } dp_cmd_type;

   typedef struct packed {
      op_type             op;
      logic               full;
      logic               scan_end;
      logic               hit;
      logic               out_free;
      logic [COUNT_W-1:0] count;
   } dp_stat_type;

endpackage
`default_nettype wire

FILE: src/dstt_ctrl.sv
// Controller state machine that sequences the scan, update and result of each event.
`default_nettype none
module dstt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  dstt_pkg::dp_stat_type stat,
   output dstt_pkg::dp_cmd_type  cmd
);
   import dstt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_APPLY = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.op == OP_QUERY) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_OK;
               state_in       = S_DONE;
            end else if (stat.op == OP_RELEASE && stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_FULL;
               state_in       = S_DONE;
            end else if (stat.scan_end) begin
               // A release past every entry goes at the tail; a remove found nothing.
               if (stat.op == OP_RELEASE) begin
                  state_in = S_APPLY;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end
            end else if (stat.hit) begin
               state_in = S_APPLY;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_APPLY: begin
            cmd.apply_release = (stat.op == OP_RELEASE);
            cmd.apply_remove  = (stat.op != OP_RELEASE);
            cmd.set_status    = 1'b1;
            cmd.status_val    = ST_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/dstt_datapath.sv
// Datapath: sorted entry registers, scan pointer, tallies and the result register.
`default_nettype none
module dstt_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [dstt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire  [dstt_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [dstt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [dstt_pkg::STATUS_W-1:0]     rsp_tuser,
   input  dstt_pkg::dp_cmd_type              cmd,
   output dstt_pkg::dp_stat_type             stat
);
   import dstt_pkg::*;

   logic [ID_W-1:0]     ent_id_ff  [ENTRIES];
   logic [GEN_W-1:0]    ent_gen_ff [ENTRIES];
   logic [DL_W-1:0]     ent_dl_ff  [ENTRIES];
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  idx_ff;
   logic [TALLY_W-1:0]  completed_ff;
   logic [TALLY_W-1:0]  overdue_ff;
   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [GEN_W-1:0]    gen_ff;
   logic [DL_W-1:0]     dl_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0] rsp_user_ff;

   logic [IDX_W-1:0]    rd_idx;
   logic [ACTIVE_W+COUNT_W-1:0] count_wide;
   logic                head_valid;

   assign rd_idx     = idx_ff[IDX_W-1:0];
   assign count_wide = {{ACTIVE_W{1'b0}}, count_ff};
   assign head_valid = (count_ff != '0);

   always_comb begin
      stat.op       = op_ff;
      stat.full     = (count_ff == COUNT_W'(ENTRIES));
      stat.scan_end = (idx_ff == count_ff);
      stat.hit      = (op_ff == OP_RELEASE) ? (ent_dl_ff[rd_idx] > dl_ff)
                                            : (ent_id_ff[rd_idx] == id_ff);
      stat.out_free = !rsp_valid_ff || rsp_tready;
      stat.count    = count_ff;
   end

   // Request capture and scan pointer; the pointer is the insert or remove slot on update.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_tuser);
         id_ff  <= req_tdata[ID_W-1:0];
         gen_ff <= req_tdata[ID_W+GEN_W-1:ID_W];
         dl_ff  <= req_tdata[ID_W+GEN_W+DL_W-1:ID_W+GEN_W];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ENTRIES; k++) begin
         if (cmd.apply_release) begin
            if (COUNT_W'(k) == idx_ff) begin
               ent_id_ff[k]  <= id_ff;
               ent_gen_ff[k] <= gen_ff;
               ent_dl_ff[k]  <= dl_ff;
            end else if (k > 0 && COUNT_W'(k) > idx_ff && COUNT_W'(k) <= count_ff) begin
               ent_id_ff[k]  <= ent_id_ff[(k > 0) ? k - 1 : 0];
               ent_gen_ff[k] <= ent_gen_ff[(k > 0) ? k - 1 : 0];
               ent_dl_ff[k]  <= ent_dl_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (cmd.apply_remove) begin
            if (k < ENTRIES - 1 && COUNT_W'(k) >= idx_ff && COUNT_W'(k + 1) < count_ff) begin
               ent_id_ff[k]  <= ent_id_ff[(k < ENTRIES - 1) ? k + 1 : k];
               ent_gen_ff[k] <= ent_gen_ff[(k < ENTRIES - 1) ? k + 1 : k];
               ent_dl_ff[k]  <= ent_dl_ff[(k < ENTRIES - 1) ? k + 1 : k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         completed_ff <= '0;
         overdue_ff   <= '0;
      end else if (cmd.apply_release) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.apply_remove) begin
         count_ff <= count_ff - 1'b1;
         if (op_ff == OP_COMPLETE) begin
            if (completed_ff != '1) begin
               completed_ff <= completed_ff + 1'b1;
            end
         end else if (overdue_ff != '1) begin
            overdue_ff <= overdue_ff + 1'b1;
         end
      end
   end

   // Result register: the beat waits here while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {1'b0,
                         overdue_ff,
                         completed_ff,
                         count_wide[ACTIVE_W-1:0],
                         head_valid ? ent_dl_ff[0]  : {DL_W{1'b0}},
                         head_valid ? ent_gen_ff[0] : {GEN_W{1'b0}},
                         head_valid ? ent_id_ff[0]  : {ID_W{1'b0}},
                         head_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

FILE: src/deadline_sorted_task_table.sv
// Top level of the deadline sorted task table: controller, datapath and checks.
`default_nettype none
// Earliest-deadline-first table of up to ENTRIES tasks. Each request beat (release,
// complete, overdue or query) produces exactly one response beat carrying a status,
// the head task and the counts as they stand after the event. Events are handled one
// at a time: each is taken in the idle state, then scans the sorted entry registers,
// one entry per step plus one more step when the scan runs past the last entry, then
// updates the table in the apply state when it changes and last loads the response in
// the done state; a query or a release into a full table goes from the scan state
// straight to the done state. The response load waits while an earlier response is
// still held. A new request is taken while the previous response still waits in the
// output register.
module deadline_sorted_task_table (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // task_id[15:0], gen_id[17:16], deadline[49:18], zero fill above
   input  wire  [dstt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[1:0]
   input  wire  [dstt_pkg::OP_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // head_valid[0], head_task_id[16:1], head_gen_id[18:17], head_deadline[50:19],
   // active_total[54:51], completed_total[70:55], overdue_total[86:71], zero fill above
   output logic [dstt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[1:0]
   output logic [dstt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import dstt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dstt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dstt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= COUNT_W'(ENTRIES))
      else $error("task count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ##1 (stat.count == $past(stat.count) || stat.count == $past(stat.count) + 1'b1 ||
           stat.count == $past(stat.count) - 1'b1))
      else $error("task count moved by more than one");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an event is in progress");

   a_result_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out) |-> (stat.out_free))
      else $error("result loaded over a beat not yet taken");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the deadline sorted task table: directed and random beats.
`default_nettype none
module tb;
   import dstt_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      op_type      op;
      logic [15:0] task_id;
      logic [1:0]  gen_id;
      logic [31:0] deadline;
   } sched_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [15:0] head_task_id;
      logic [1:0]  head_gen_id;
      logic [31:0] head_deadline;
      logic [3:0]  active_total;
      logic [15:0] completed_total;
      logic [15:0] overdue_total;
   } table_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tready = 1'b0;
   logic req_tready;
   logic rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   deadline_sorted_task_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow copy of the task table, kept in deadline order.
   logic [15:0] shadow_ids [ENTRIES];
   logic [1:0]  shadow_gens [ENTRIES];
   logic [31:0] shadow_deadlines [ENTRIES];
   int          shadow_used = 0;
   logic [15:0] shadow_completed = '0;
   logic [15:0] shadow_overdue = '0;

   sched_item_type   sched_backlog [$];
   table_report_type expected_reports [$];
   sched_item_type   beat_on_bus;
   table_report_type next_report;
   table_report_type predicted;
   table_report_type observed;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int stuck_cycles = 0;

   task automatic advance_table(input sched_item_type ev, output table_report_type rep);
      int pos;
      int k;
      rep = '0;
      pos = 0;
      case (ev.op)
         OP_RELEASE: begin
            if (shadow_used >= ENTRIES) begin
               rep.status = ST_FULL;
            end else begin
               // Equal deadlines keep arrival order, so walk past them.
               while (pos < shadow_used && shadow_deadlines[pos] <= ev.deadline) pos++;
               for (k = shadow_used; k > pos; k--) begin
                  shadow_ids[k] = shadow_ids[k-1];
                  shadow_gens[k] = shadow_gens[k-1];
                  shadow_deadlines[k] = shadow_deadlines[k-1];
               end
               shadow_ids[pos] = ev.task_id;
               shadow_gens[pos] = ev.gen_id;
               shadow_deadlines[pos] = ev.deadline;
               shadow_used++;
               rep.status = ST_OK;
            end
         end
         OP_COMPLETE, OP_OVERDUE: begin
            while (pos < shadow_used && shadow_ids[pos] != ev.task_id) pos++;
            if (pos >= shadow_used) begin
               rep.status = ST_NOT_FOUND;
            end else begin
               for (k = pos; k + 1 < shadow_used; k++) begin
                  shadow_ids[k] = shadow_ids[k+1];
                  shadow_gens[k] = shadow_gens[k+1];
                  shadow_deadlines[k] = shadow_deadlines[k+1];
               end
               shadow_used--;
               if (ev.op == OP_COMPLETE) begin
                  if (shadow_completed != 16'hFFFF) shadow_completed++;
               end else begin
                  if (shadow_overdue != 16'hFFFF) shadow_overdue++;
               end
               rep.status = ST_OK;
            end
         end
         default: rep.status = ST_OK;
      endcase
      if (shadow_used > 0) begin
         rep.head_valid = 1'b1;
         rep.head_task_id = shadow_ids[0];
         rep.head_gen_id = shadow_gens[0];
         rep.head_deadline = shadow_deadlines[0];
      end
      rep.active_total = shadow_used[3:0];
      rep.completed_total = shadow_completed;
      rep.overdue_total = shadow_overdue;
   endtask

   task automatic queue_item(input op_type op, input logic [15:0] id, input logic [1:0] gen,
                             input logic [31:0] dl);
      sched_item_type it;
      it.op = op;
      it.task_id = id;
      it.gen_id = gen;
      it.deadline = dl;
      sched_backlog.push_back(it);
   endtask

   // Ids mostly come from a small pool so that removes hit and duplicates occur.
   function automatic sched_item_type random_item(input int release_pct);
      sched_item_type it;
      int pick;
      pick = $urandom_range(9);
      if ($urandom_range(99) < release_pct) it.op = OP_RELEASE;
      else if (pick < 6) it.op = OP_COMPLETE;
      else if (pick < 9) it.op = OP_OVERDUE;
      else it.op = OP_QUERY;
      pick = $urandom_range(13);
      if (pick < 10) it.task_id = 16'(pick);
      else if (pick == 10) it.task_id = 16'hFFFF;
      else if (pick == 11) it.task_id = 16'h8000;
      else it.task_id = 16'($urandom_range(65535));
      it.gen_id = 2'($urandom_range(3));
      case ($urandom_range(4))
         0: it.deadline = $urandom;
         1: it.deadline = 32'($urandom_range(7));
         2: it.deadline = 32'hFFFF_FFF8 + 32'($urandom_range(7));
         3: it.deadline = 32'h7FFF_FFFC + 32'($urandom_range(7));
         default: it.deadline = 32'(1000 + $urandom_range(3));
      endcase
      return it;
   endfunction

   task automatic wait_until_idle();
      do @(negedge clock);
      while (sched_backlog.size() != 0 || req_tvalid || expected_reports.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Request side: present the next pending beat, predicting each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_table(beat_on_bus, next_report);
            expected_reports.push_back(next_report);
         end
         if (!req_tvalid || req_tready) begin
            if (sched_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_bus = sched_backlog.pop_front();
               req_tdata <= {6'd0, beat_on_bus.deadline, beat_on_bus.gen_id,
                             beat_on_bus.task_id};
               req_tuser <= beat_on_bus.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random back-pressure and a field-by-field check of every beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            observed.status = rsp_tuser;
            observed.head_valid = rsp_tdata[0];
            observed.head_task_id = rsp_tdata[16:1];
            observed.head_gen_id = rsp_tdata[18:17];
            observed.head_deadline = rsp_tdata[50:19];
            observed.active_total = rsp_tdata[54:51];
            observed.completed_total = rsp_tdata[70:55];
            observed.overdue_total = rsp_tdata[86:71];
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response beat, expected none actual %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               predicted = expected_reports.pop_front();
               check_field("status", predicted.status, observed.status);
               check_field("head_valid", predicted.head_valid, observed.head_valid);
               check_field("head_task_id", predicted.head_task_id, observed.head_task_id);
               check_field("head_gen_id", predicted.head_gen_id, observed.head_gen_id);
               check_field("head_deadline", predicted.head_deadline, observed.head_deadline);
               check_field("active_total", predicted.active_total, observed.active_total);
               check_field("completed_total", predicted.completed_total,
                           observed.completed_total);
               check_field("overdue_total", predicted.overdue_total, observed.overdue_total);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int phase;
      int n;
      int bias;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Empty table, extreme ids and deadlines, ties, a full table, duplicates.
      queue_item(OP_QUERY, 16'hFFFF, 2'd3, 32'hFFFF_FFFF);
      queue_item(OP_COMPLETE, 16'h0000, 2'd0, 32'h0);
      queue_item(OP_OVERDUE, 16'hFFFF, 2'd3, 32'hFFFF_FFFF);
      queue_item(OP_RELEASE, 16'h0000, 2'd0, 32'hFFFF_FFFF);
      queue_item(OP_RELEASE, 16'hFFFF, 2'd3, 32'h0000_0000);
      queue_item(OP_RELEASE, 16'd5, 2'd1, 32'd1000);
      queue_item(OP_RELEASE, 16'd6, 2'd2, 32'd1000);
      queue_item(OP_RELEASE, 16'd7, 2'd1, 32'd1000);
      queue_item(OP_RELEASE, 16'd5, 2'd2, 32'hFFFF_FFFF);
      queue_item(OP_RELEASE, 16'd9, 2'd3, 32'h8000_0000);
      queue_item(OP_RELEASE, 16'd10, 2'd0, 32'h7FFF_FFFF);
      queue_item(OP_RELEASE, 16'd11, 2'd1, 32'd3);
      queue_item(OP_QUERY, 16'h1234, 2'd2, 32'h5555_AAAA);
      queue_item(OP_COMPLETE, 16'h1234, 2'd1, 32'd7);
      queue_item(OP_COMPLETE, 16'd5, 2'd3, 32'hFFFF_FFFF);
      queue_item(OP_OVERDUE, 16'hFFFF, 2'd0, 32'd0);
      queue_item(OP_OVERDUE, 16'd5, 2'd1, 32'd9);
      queue_item(OP_COMPLETE, 16'h0000, 2'd2, 32'd0);
      queue_item(OP_RELEASE, 16'd12, 2'd3, 32'd1000);
      queue_item(OP_QUERY, 16'hA5A5, 2'd1, 32'hDEAD_BEEF);
      queue_item(OP_COMPLETE, 16'd6, 2'd0, 32'd0);
      queue_item(OP_OVERDUE, 16'd7, 2'd0, 32'd0);
      queue_item(OP_COMPLETE, 16'd9, 2'd0, 32'd0);
      queue_item(OP_OVERDUE, 16'd10, 2'd0, 32'd0);
      queue_item(OP_COMPLETE, 16'd12, 2'd0, 32'd0);
      wait_until_idle();

      // Four random phases with different idling; each ends with the sender held
      // back until every response has been seen.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         bias = 50;
         for (n = 0; n < 275; n++) begin
            // Swing between filling and emptying the table in short bursts.
            if (n % 16 == 0) bias = 25 * (1 + $urandom_range(2));
            sched_backlog.push_back(random_item(bias));
         end
         wait_until_idle();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      queue_item(OP_RELEASE, 16'd3, 2'd2, 32'd40);
      queue_item(OP_OVERDUE, 16'd3, 2'd1, 32'd0);
      queue_item(OP_QUERY, 16'd0, 2'd0, 32'd0);
      wait_until_idle();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
